// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is ignored while reset is high.
`define SWBC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion lbl failed");

// Concurrent assertion that is also checked around reset.
`define SWBC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion lbl failed");

`endif

// ----- hw/rtl/swbc_pkg.sv -----
// Package of the sector write-back cache policy controller: widths, codes, types.
// No dependencies.
`default_nettype none
package swbc_pkg;
   localparam int SLOT_COUNT_DEF = 16;
   localparam int ADDR_W = 32;
   localparam int CNT_W  = 32;
   localparam int ACT_W  = 3;
   localparam int SLOT_W = 6;
   localparam int OP_W   = 2;

   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_SYNC  = 2'd2;
   localparam logic [OP_W-1:0] OP_INV   = 2'd3;

   localparam logic [ACT_W-1:0] ACT_HIT    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_FILL   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_WB     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_BYPASS = 3'd4;
   localparam logic [ACT_W-1:0] ACT_DONE   = 3'd5;

   typedef enum logic [2:0] {
      K_READ, K_WRITE, K_SYNC, K_INV, K_BYPASS, K_DONE
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] addr;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_RESOLVE, S_INSTALL, S_SYNC, S_SIMPLE
   } state_type;
endpackage
`default_nettype wire

// ----- hw/rtl/swbc_front.sv -----
// Front part: accepts request beats, classifies them and queues commands.
// Depends on swbc_pkg.
`default_nettype none
module swbc_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_write_enable,
   input  wire                         csr_write_data,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [swbc_pkg::OP_W-1:0]   req_opcode,
   input  wire  [swbc_pkg::ADDR_W-1:0] req_block_address,
   output logic                        cmd_valid,
   input  wire                         cmd_ready,
   output swbc_pkg::cmd_type           cmd
);
   import swbc_pkg::*;

   logic          enable_ff;
   cmd_type       q_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff;
   cmd_type       cls;
   logic          push, pop;

   always_comb begin
      cls.addr = req_block_address;
      unique case (req_opcode)
         OP_READ:  cls.kind = enable_ff ? K_READ : K_BYPASS;
         OP_WRITE: cls.kind = enable_ff ? K_WRITE : K_BYPASS;
         OP_SYNC:  cls.kind = enable_ff ? K_SYNC : K_DONE;
         default:  cls.kind = K_INV;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (csr_write_enable) enable_ff <= csr_write_data;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) q_ff[wr_ptr_ff] <= cls;
   end
endmodule
`default_nettype wire

// ----- hw/rtl/swbc_back.sv -----
// Back part: scans the slot table, applies the replacement policy and issues result beats.
// Depends on swbc_pkg.
`default_nettype none
module swbc_back #(
   parameter int SLOT_COUNT = swbc_pkg::SLOT_COUNT_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         cmd_valid,
   output logic                        cmd_ready,
   input  swbc_pkg::cmd_type           cmd,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [swbc_pkg::ACT_W-1:0]  rsp_action,
   output logic [swbc_pkg::SLOT_W-1:0] rsp_slot_index,
   output logic [swbc_pkg::ADDR_W-1:0] rsp_disk_address,
   output logic                        rsp_is_last,
   output logic [swbc_pkg::CNT_W-1:0]  rsp_hit_total,
   output logic [swbc_pkg::CNT_W-1:0]  rsp_miss_total
);
   import swbc_pkg::*;

   localparam int IW = $clog2(SLOT_COUNT);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     victim_ff, victim_in;

   logic              valid_ff [SLOT_COUNT];
   logic              valid_in [SLOT_COUNT];
   logic              dirty_ff [SLOT_COUNT];
   logic              dirty_in [SLOT_COUNT];
   logic [ADDR_W-1:0] saddr_ff [SLOT_COUNT];
   logic [CNT_W-1:0]  stamp_ff [SLOT_COUNT];

   logic              stamp_we, saddr_we;
   logic [IW-1:0]     stamp_wi, saddr_wi;

   logic [CNT_W-1:0]  use_clock_ff, use_clock_in;
   logic [CNT_W-1:0]  hit_ff, hit_in, miss_ff, miss_in;

   logic              match_ff, match_in, free_ff, free_in, clean_ff, clean_in;
   logic [IW-1:0]     match_idx_ff, match_idx_in, free_idx_ff, free_idx_in;
   logic [IW-1:0]     clean_idx_ff, clean_idx_in, any_idx_ff, any_idx_in;
   logic [CNT_W-1:0]  clean_stamp_ff, clean_stamp_in, any_stamp_ff, any_stamp_in;
   logic [ADDR_W-1:0] any_addr_ff, any_addr_in;

   logic              rv_ff, rv_in, last_ff, last_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] daddr_ff, daddr_in;
   logic [CNT_W-1:0]  ht_ff, ht_in, mt_ff, mt_in;

   logic              out_free;
   logic [CNT_W-1:0]  stamp_new;
   logic              sv, sd;
   logic [ADDR_W-1:0] sa;
   logic [CNT_W-1:0]  ss;
   logic [IW-1:0]     vic;

   assign out_free  = !rv_ff || rsp_ready;
   assign stamp_new = use_clock_ff + 1'b1;
   assign sv = valid_ff[idx_ff];
   assign sd = dirty_ff[idx_ff];
   assign sa = saddr_ff[idx_ff];
   assign ss = stamp_ff[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff; addr_in = addr_ff; idx_in = idx_ff; victim_in = victim_ff;
      valid_in = valid_ff; dirty_in = dirty_ff;
      stamp_we = 1'b0; stamp_wi = idx_ff; saddr_we = 1'b0; saddr_wi = idx_ff;
      use_clock_in = use_clock_ff; hit_in = hit_ff; miss_in = miss_ff;
      match_in = match_ff; free_in = free_ff; clean_in = clean_ff;
      match_idx_in = match_idx_ff; free_idx_in = free_idx_ff;
      clean_idx_in = clean_idx_ff; any_idx_in = any_idx_ff;
      clean_stamp_in = clean_stamp_ff; any_stamp_in = any_stamp_ff;
      any_addr_in = any_addr_ff;
      rv_in = rv_ff && !rsp_ready;
      act_in = act_ff; slot_in = slot_ff; daddr_in = daddr_ff; last_in = last_ff;
      ht_in = ht_ff; mt_in = mt_ff;
      cmd_ready = 1'b0;
      vic = free_ff ? free_idx_ff : clean_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               kind_in  = cmd.kind;
               addr_in  = cmd.addr;
               idx_in   = '0;
               match_in = 1'b0; free_in = 1'b0; clean_in = 1'b0;
               unique case (cmd.kind)
                  K_READ, K_WRITE: state_in = S_SCAN;
                  K_SYNC:          state_in = S_SYNC;
                  default:         state_in = S_SIMPLE;
               endcase
            end
         end
         S_SCAN: begin
            if (sv && sa == addr_ff && !match_ff) begin
               match_in = 1'b1; match_idx_in = idx_ff;
            end
            if (!sv && !free_ff) begin
               free_in = 1'b1; free_idx_in = idx_ff;
            end
            if (!sd && (!clean_ff || ss < clean_stamp_ff)) begin
               clean_in = 1'b1; clean_idx_in = idx_ff; clean_stamp_in = ss;
            end
            if (idx_ff == '0 || ss < any_stamp_ff) begin
               any_idx_in = idx_ff; any_stamp_in = ss; any_addr_in = sa;
            end
            if (idx_ff == LAST_IDX) state_in = S_RESOLVE;
            else idx_in = idx_ff + 1'b1;
         end
         S_RESOLVE: begin
            if (out_free) begin
               rv_in = 1'b1; ht_in = hit_ff; mt_in = miss_ff;
               if (match_ff) begin
                  use_clock_in = stamp_new;
                  stamp_we = 1'b1; stamp_wi = match_idx_ff;
                  slot_in = SLOT_W'(match_idx_ff); daddr_in = '0; last_in = 1'b1;
                  if (kind_ff == K_READ) begin
                     hit_in = hit_ff + 1'b1; ht_in = hit_in; act_in = ACT_HIT;
                  end else begin
                     dirty_in[match_idx_ff] = 1'b1; act_in = ACT_WRITE;
                  end
                  state_in = S_IDLE;
               end else begin
                  if (kind_ff == K_READ) begin
                     miss_in = miss_ff + 1'b1; mt_in = miss_in;
                  end
                  if (free_ff || clean_ff) begin
                     use_clock_in = stamp_new;
                     valid_in[vic] = 1'b1;
                     dirty_in[vic] = (kind_ff == K_WRITE);
                     stamp_we = 1'b1; stamp_wi = vic; saddr_we = 1'b1; saddr_wi = vic;
                     act_in = (kind_ff == K_READ) ? ACT_FILL : ACT_WRITE;
                     slot_in = SLOT_W'(vic);
                     daddr_in = (kind_ff == K_READ) ? addr_ff : '0;
                     last_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     // Every slot is valid and dirty: write back the oldest first.
                     act_in = ACT_WB; slot_in = SLOT_W'(any_idx_ff);
                     daddr_in = any_addr_ff; last_in = 1'b0;
                     dirty_in[any_idx_ff] = 1'b0;
                     victim_in = any_idx_ff;
                     state_in = S_INSTALL;
                  end
               end
            end
         end
         S_INSTALL: begin
            if (out_free) begin
               use_clock_in = stamp_new;
               valid_in[victim_ff] = 1'b1;
               dirty_in[victim_ff] = (kind_ff == K_WRITE);
               stamp_we = 1'b1; stamp_wi = victim_ff; saddr_we = 1'b1; saddr_wi = victim_ff;
               rv_in = 1'b1; ht_in = hit_ff; mt_in = miss_ff;
               act_in = (kind_ff == K_READ) ? ACT_FILL : ACT_WRITE;
               slot_in = SLOT_W'(victim_ff);
               daddr_in = (kind_ff == K_READ) ? addr_ff : '0;
               last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SYNC: begin
            if (!(sv && sd) || out_free) begin
               if (sv && sd) begin
                  rv_in = 1'b1; ht_in = hit_ff; mt_in = miss_ff;
                  act_in = ACT_WB; slot_in = SLOT_W'(idx_ff); daddr_in = sa;
                  last_in = 1'b0;
                  dirty_in[idx_ff] = 1'b0;
               end
               if (idx_ff == LAST_IDX) begin
                  kind_in = K_DONE; state_in = S_SIMPLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_SIMPLE: begin
            if (out_free) begin
               if (kind_ff == K_INV) begin
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     valid_in[i] = 1'b0; dirty_in[i] = 1'b0;
                  end
               end
               rv_in = 1'b1; ht_in = hit_ff; mt_in = miss_ff;
               slot_in = '0; last_in = 1'b1;
               if (kind_ff == K_BYPASS) begin
                  act_in = ACT_BYPASS; daddr_in = addr_ff;
               end else begin
                  act_in = ACT_DONE; daddr_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            valid_ff[i] <= 1'b0; dirty_ff[i] <= 1'b0;
         end
         use_clock_ff <= CNT_W'(1);
         hit_ff <= '0; miss_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in; dirty_ff <= dirty_in;
         use_clock_ff <= use_clock_in;
         hit_ff <= hit_in; miss_ff <= miss_in;
         rv_ff <= rv_in;
      end
      if (stamp_we) stamp_ff[stamp_wi] <= stamp_new;
      if (saddr_we) saddr_ff[saddr_wi] <= addr_ff;
      kind_ff <= kind_in; addr_ff <= addr_in; idx_ff <= idx_in; victim_ff <= victim_in;
      match_ff <= match_in; free_ff <= free_in; clean_ff <= clean_in;
      match_idx_ff <= match_idx_in; free_idx_ff <= free_idx_in;
      clean_idx_ff <= clean_idx_in; any_idx_ff <= any_idx_in;
      clean_stamp_ff <= clean_stamp_in; any_stamp_ff <= any_stamp_in;
      any_addr_ff <= any_addr_in;
      act_ff <= act_in; slot_ff <= slot_in; daddr_ff <= daddr_in; last_ff <= last_in;
      ht_ff <= ht_in; mt_ff <= mt_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_action       = act_ff;
   assign rsp_slot_index   = slot_ff;
   assign rsp_disk_address = daddr_ff;
   assign rsp_is_last      = last_ff;
   assign rsp_hit_total    = ht_ff;
   assign rsp_miss_total   = mt_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/sector_write_back_cache_policy.sv -----
// Top level of the sector write-back cache policy controller.
// Depends on swbc_pkg, swbc_front and swbc_back.
//
// Fully associative LRU write-back tag controller. A request beat enters a
// two-entry command queue in the front part; the back part handles one
// command at a time. A read or write scans the slot table one slot per
// clock, then resolves; when every slot is valid and dirty, the oldest
// is written back first. A sync walks the table and stalls on a dirty
// slot while the output is held; bypass, done and invalidate need no scan.
// Results come from an output register, so the next command proceeds
// while a result beat waits. cache_enable resets to 0.
`default_nettype none
module sector_write_back_cache_policy #(
   parameter int SLOT_COUNT = swbc_pkg::SLOT_COUNT_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_write_enable,
   input  wire                         csr_write_data,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  [swbc_pkg::OP_W-1:0]   req_opcode,
   input  wire  [swbc_pkg::ADDR_W-1:0] req_block_address,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [swbc_pkg::ACT_W-1:0]  rsp_action,
   output logic [swbc_pkg::SLOT_W-1:0] rsp_slot_index,
   output logic [swbc_pkg::ADDR_W-1:0] rsp_disk_address,
   output logic                        rsp_is_last,
   output logic [swbc_pkg::CNT_W-1:0]  rsp_hit_total,
   output logic [swbc_pkg::CNT_W-1:0]  rsp_miss_total
);
   import swbc_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   swbc_front u_front (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_ready, .req_opcode, .req_block_address,
      .cmd_valid, .cmd_ready, .cmd
   );

   swbc_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid, .rsp_ready, .rsp_action, .rsp_slot_index,
      .rsp_disk_address, .rsp_is_last, .rsp_hit_total, .rsp_miss_total
   );
endmodule
`default_nettype wire

// ----- hw/rtl/swbc_checker.sv -----
// Port-level assertions for the cache policy controller, bound to the top level.
// Depends on swbc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module swbc_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [swbc_pkg::ACT_W-1:0]   rsp_action,
   input wire [swbc_pkg::SLOT_W-1:0]  rsp_slot_index,
   input wire [swbc_pkg::ADDR_W-1:0]  rsp_disk_address,
   input wire                         rsp_is_last
);
   import swbc_pkg::*;

   `SWBC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action))
   `SWBC_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid)
   `SWBC_ASSERT(a_bypass_form, clock, reset, rsp_valid && rsp_action == ACT_BYPASS |-> rsp_is_last && rsp_slot_index == '0)
   `SWBC_ASSERT(a_hit_form, clock, reset, rsp_valid && rsp_action == ACT_HIT |-> rsp_is_last && rsp_disk_address == '0)
   `SWBC_ASSERT(a_only_wb_not_last, clock, reset, rsp_valid && !rsp_is_last |-> rsp_action == ACT_WB)
endmodule

bind sector_write_back_cache_policy swbc_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_action, .rsp_slot_index,
   .rsp_disk_address, .rsp_is_last
);
`default_nettype wire
